>>> rtl/ket_pkg.sv
`default_nettype none
package ket_pkg;

  // Table geometry and register defaults
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned CAP_W           = 6;
  localparam logic [CAP_W-1:0] CAP_RESET  = 6'd32;

  // Field widths
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned ENTRY_W  = KEY_W + PAY_W;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP          = 3'd2;
  localparam logic [STATUS_W-1:0] ST_GET_MISS     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEL_MISS     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UPD_MISS     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UPD_CONFLICT = 3'd6;

  typedef enum logic [1:0] {
    KET_IDLE,
    KET_SCAN,
    KET_SHIFT,
    KET_FINISH
  } ket_state_t;

endpackage
`default_nettype wire

>>> rtl/keyed_entry_table.sv
// Scan: add, get, update, clear and unknown requests read all n entries held before
//   the result; a delete hitting slot h then shifts every later slot down one place,
//   since one slot is read per cycle.
// Requests: one at a time; a new request is taken only after the last result is
//   registered, and a stalled result holds the sequencer.
// Reset: entry count clears, capacity returns to 32; slot contents stay as they are.
`default_nettype none
module keyed_entry_table
  import ket_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration: capacity register
  input  wire logic                cfg_wr_en,
  input  wire logic [CAP_W-1:0]    cfg_wr_data,
  // request channel
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [127:0]        in_tdata,   // key[31:0], new_key[63:32], payload[127:64]
  input  wire logic [REQ_W-1:0]    in_tuser,   // req_type[2:0]
  // result channel
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [103:0]             out_tdata,  // found_key[31:0], found_payload[95:32],
                                               // entry_count[101:96], zero[103:102]
  output logic [STATUS_W-1:0]      out_tuser   // status[2:0]
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(TABLE_DEPTH);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  ket_state_t state_r, state_nxt;

  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     count_r, count_nxt;

  // latched request
  logic [REQ_W-1:0]  req_r;
  logic [KEY_W-1:0]  key_r, nkey_r;
  logic [PAY_W-1:0]  pay_r;

  // scan results
  logic              hit_r;
  logic [AW-1:0]     hit_idx_r;
  logic              conflict_r;
  logic [KEY_W-1:0]  fkey_r;
  logic [PAY_W-1:0]  fpay_r;

  // shared read pipeline: issue index, returned-data valid and its index
  logic [CW-1:0]     issue_r, issue_nxt;
  logic              rvalid_r;
  logic [AW-1:0]     cmp_idx_r;

  // result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [PAY_W-1:0]    out_pay_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  // ---------------------------------------------------------------------
  // Slot memory: {payload, id}
  // ---------------------------------------------------------------------
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  ket_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  logic [KEY_W-1:0] rd_id;
  logic [PAY_W-1:0] rd_pay;
  assign rd_id  = ram_rdata[KEY_W-1:0];
  assign rd_pay = ram_rdata[ENTRY_W-1:KEY_W];

  // ---------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------
  logic in_acc;
  logic issue_en;
  logic pipe_done;
  logic out_free;
  logic commit;
  logic shift_we;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      KET_IDLE: begin
        if (in_acc) begin
          state_nxt = KET_SCAN;
        end
      end
      KET_SCAN: begin
        if (pipe_done) begin
          state_nxt = (req_r == REQ_DELETE && hit_r) ? KET_SHIFT : KET_FINISH;
        end
      end
      KET_SHIFT: begin
        if (pipe_done) begin
          state_nxt = KET_FINISH;
        end
      end
      KET_FINISH: begin
        if (out_free) begin
          state_nxt = KET_IDLE;
        end
      end
      default: state_nxt = KET_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    issue_en  = 1'b0;
    commit    = 1'b0;
    shift_we  = 1'b0;
    case (state_r)
      KET_IDLE: begin
        in_tready = 1'b1;
      end
      KET_SCAN: begin
        issue_en = (issue_r < count_r);
      end
      KET_SHIFT: begin
        issue_en = (issue_r < count_r);
        shift_we = rvalid_r;
      end
      KET_FINISH: begin
        commit = out_free;
      end
      default: ;
    endcase
  end

  assign in_acc    = in_tvalid && in_tready;
  assign pipe_done = !issue_en && !rvalid_r;
  assign out_free  = !out_valid_r || out_tready;

  // Next issue index: restart at zero for a scan, just past the hit for a shift
  always_comb begin
    issue_nxt = issue_r;
    if (in_acc) begin
      issue_nxt = '0;
    end else if (state_r == KET_SCAN && pipe_done) begin
      issue_nxt = CW'(hit_idx_r) + CW'(1);
    end else if (issue_en) begin
      issue_nxt = issue_r + CW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Decision for the finishing cycle
  // ---------------------------------------------------------------------
  logic [CMPW-1:0]     eff_cap;
  logic                is_full;
  logic [STATUS_W-1:0] status_c;
  logic                add_ok, upd_ok;
  logic [KEY_W-1:0]    res_key;
  logic [PAY_W-1:0]    res_pay;

  assign eff_cap = (CMPW'(cap_r) > DEPTH_C) ? DEPTH_C : CMPW'(cap_r);
  assign is_full = (CMPW'(count_r) >= eff_cap);

  always_comb begin
    status_c  = ST_OK;
    add_ok    = 1'b0;
    upd_ok    = 1'b0;
    res_key   = '0;
    res_pay   = '0;
    count_nxt = count_r;
    case (req_r)
      REQ_ADD: begin
        if (is_full) begin
          status_c = ST_FULL;
        end else if (hit_r) begin
          status_c = ST_DUP;
        end else begin
          add_ok    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_DELETE: begin
        if (hit_r) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_c = ST_DEL_MISS;
        end
      end
      REQ_GET: begin
        if (hit_r) begin
          res_key = fkey_r;
          res_pay = fpay_r;
        end else begin
          status_c = ST_GET_MISS;
        end
      end
      REQ_UPDATE: begin
        // another entry holding the new id wins over a missing target
        if (conflict_r) begin
          status_c = ST_UPD_CONFLICT;
        end else if (hit_r) begin
          upd_ok = 1'b1;
        end else begin
          status_c = ST_UPD_MISS;
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  // Write port: shift moves slot i+1 down to i; finish writes add or update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    if (shift_we) begin
      ram_we    = 1'b1;
      ram_waddr = cmp_idx_r - AW'(1);
    end else if (commit && add_ok) begin
      ram_we    = 1'b1;
      ram_waddr = count_r[AW-1:0];
      ram_wdata = {pay_r, key_r};
    end else if (commit && upd_ok) begin
      ram_we    = 1'b1;
      ram_waddr = hit_idx_r;
      ram_wdata = {pay_r, nkey_r};
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= KET_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= issue_en;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    issue_r   <= issue_nxt;
    cmp_idx_r <= issue_r[AW-1:0];

    // latch the request
    if (in_acc) begin
      req_r      <= in_tuser;
      key_r      <= in_tdata[31:0];
      nkey_r     <= in_tdata[63:32];
      pay_r      <= in_tdata[127:64];
      hit_r      <= 1'b0;
      conflict_r <= 1'b0;
    end else if (state_r == KET_SCAN && rvalid_r) begin
      // compare each returned slot against key and new_key
      if (rd_id == key_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
        fkey_r    <= rd_id;
        fpay_r    <= rd_pay;
      end else if (rd_id == nkey_r) begin
        conflict_r <= 1'b1;
      end
    end

    // hold the result until taken
    if (commit) begin
      out_status_r <= status_c;
      out_key_r    <= res_key;
      out_pay_r    <= res_pay;
      out_cnt_r    <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_pay_r, out_key_r};

endmodule
`default_nettype wire

>>> rtl/ket_ram.sv
`default_nettype none
module ket_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import ket_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  // Request codes the block must ignore (no entry in the package for these)
  localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_LAST  = 3'd7;

  localparam int KEY_POOL_N = 40;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] new_key;
    logic [PAY_W-1:0] payload;
  } table_req_t;

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     found_key;
    logic [PAY_W-1:0]     found_payload;
    logic [CNT_OUT_W-1:0] entry_count;
  } table_resp_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]     cfg_wr_data = '0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [127:0]         in_tdata    = '0;   // key[31:0], new_key[63:32], payload[127:64]
  logic [REQ_W-1:0]     in_tuser    = '0;   // req_type[2:0]
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [103:0]         out_tdata;          // found_key[31:0], found_payload[95:32],
                                            // entry_count[101:96], zero[103:102]
  logic [STATUS_W-1:0]  out_tuser;          // status[2:0]

  keyed_entry_table u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the table, updated as each request is accepted
  logic [KEY_W-1:0] shadow_ids [DEPTH];
  logic [PAY_W-1:0] shadow_pays[DEPTH];
  int               shadow_count;
  int               shadow_cap;

  table_req_t  pending_reqs[$];
  table_resp_t table_results[$];

  logic [KEY_W-1:0] key_pool[KEY_POOL_N];

  int  queued_count   = 0;
  int  accepted_count = 0;
  int  checked_count  = 0;
  int  fail_count     = 0;
  int  cap_writes     = 0;
  int  status_seen[8];
  bit  in_accepted    = 1'b0;
  int  sender_idle_pct = 0;
  int  recv_stall_pct  = 0;

  // Return the slot holding id, or -1 when it is not in the table.
  function automatic int shadow_find(logic [KEY_W-1:0] id);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_ids[i] == id) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the result it produces.
  function automatic table_resp_t table_predict(table_req_t r);
    table_resp_t res;
    int          hit;
    int          lim;
    bit          conflict;
    res.status        = ST_OK;
    res.found_key     = '0;
    res.found_payload = '0;
    lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    hit = shadow_find(r.key);
    case (r.kind)
      REQ_ADD: begin
        if (shadow_count >= lim) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_DUP;
        end else begin
          shadow_ids[shadow_count]  = r.key;
          shadow_pays[shadow_count] = r.payload;
          shadow_count++;
        end
      end
      REQ_DELETE: begin
        if (hit < 0) begin
          res.status = ST_DEL_MISS;
        end else begin
          // close the gap: later entries move down one slot
          for (int i = hit; i + 1 < shadow_count; i++) begin
            shadow_ids[i]  = shadow_ids[i+1];
            shadow_pays[i] = shadow_pays[i+1];
          end
          shadow_count--;
        end
      end
      REQ_GET: begin
        if (hit < 0) begin
          res.status = ST_GET_MISS;
        end else begin
          res.found_key     = shadow_ids[hit];
          res.found_payload = shadow_pays[hit];
        end
      end
      REQ_UPDATE: begin
        // a clash with any other entry beats a missing target
        conflict = 1'b0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_ids[i] != r.key && shadow_ids[i] == r.new_key) conflict = 1'b1;
        end
        if (conflict) begin
          res.status = ST_UPD_CONFLICT;
        end else if (hit < 0) begin
          res.status = ST_UPD_MISS;
        end else begin
          shadow_ids[hit]  = r.new_key;
          shadow_pays[hit] = r.payload;
        end
      end
      REQ_CLEAR: shadow_count = 0;
      default: ;   // unknown codes change nothing
    endcase
    res.entry_count = shadow_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Request driver: change inputs on the falling edge, hold until accepted.
  always @(negedge clk) begin : drive_requests
    table_req_t nxt;
    logic       drive_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_accepted)) begin
      drive_valid = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_tdata    <= {nxt.payload, nxt.new_key, nxt.key};
        in_tuser    <= nxt.kind;
        drive_valid = 1'b1;
      end
      in_tvalid <= drive_valid;
    end
  end

  // Result receiver: stall at random per the current phase.
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: sample both channels on the rising edge, predict, compare.
  always @(posedge clk) begin : watch_table
    table_req_t  req;
    table_resp_t want;
    table_resp_t got;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_cap   = int'(CAP_RESET);
      in_accepted  = 1'b0;
    end else begin
      if (cfg_wr_en) shadow_cap = int'(cfg_wr_data);
      in_accepted = in_tvalid && in_tready;
      if (in_accepted) begin
        req.kind    = in_tuser;
        req.key     = in_tdata[31:0];
        req.new_key = in_tdata[63:32];
        req.payload = in_tdata[127:64];
        table_results.push_back(table_predict(req));
        accepted_count++;
      end
      if (out_tvalid && out_tready) begin
        got.status        = out_tuser;
        got.found_key     = out_tdata[31:0];
        got.found_payload = out_tdata[95:32];
        got.entry_count   = out_tdata[101:96];
        if (table_results.size() == 0) begin
          $error("result with no request outstanding: status %0d", got.status);
          fail_count++;
        end else begin
          want = table_results.pop_front();
          checked_count++;
          status_seen[want.status]++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.found_key !== want.found_key) begin
            $error("found_key: expected %08h, got %08h", want.found_key, got.found_key);
            fail_count++;
          end
          if (got.found_payload !== want.found_payload) begin
            $error("found_payload: expected %016h, got %016h",
                   want.found_payload, got.found_payload);
            fail_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [KEY_W-1:0] new_key, input logic [PAY_W-1:0] payload);
    table_req_t r;
    r.kind    = kind;
    r.key     = key;
    r.new_key = new_key;
    r.payload = payload;
    pending_reqs.push_back(r);
    queued_count++;
  endtask

  // Block the caller until every request is in and every result is out,
  // then wait a margin scaled to the table depth before anything else happens.
  task automatic wait_drained();
    while (accepted_count != queued_count || table_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cap_writes++;
  endtask

  // Mostly keys from a small pool so that hits, duplicates and clashes are common.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  task automatic queue_random_req();
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;
    int               roll;
    k    = pick_key();
    nk   = ($urandom_range(0, 9) == 0) ? k : pick_key();
    roll = $urandom_range(0, 99);
    if (roll < 35)      queue_req(REQ_ADD, k, nk, {$urandom, $urandom});
    else if (roll < 55) queue_req(REQ_DELETE, k, nk, {$urandom, $urandom});
    else if (roll < 75) queue_req(REQ_GET, k, nk, {$urandom, $urandom});
    else if (roll < 93) queue_req(REQ_UPDATE, k, nk, {$urandom, $urandom});
    else if (roll < 96) queue_req(REQ_CLEAR, k, nk, {$urandom, $urandom});
    else queue_req(REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST)), k, nk,
                   {$urandom, $urandom});
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                           input int stall_pct, input int fill_n, input int n);
    write_capacity(cap);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    // fill burst first, so the table really runs up against its limit
    for (int i = 0; i < fill_n; i++) queue_req(REQ_ADD, $urandom, $urandom, {$urandom, $urandom});
    for (int i = 0; i < n; i++) queue_random_req();
  endtask

  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset capacity: lookups on an empty table first
    queue_req(REQ_GET,    32'h0, 32'h0, 64'h0);
    queue_req(REQ_DELETE, 32'h0, 32'h0, 64'h0);
    queue_req(REQ_UPDATE, 32'h0, 32'h1, 64'h0);
    // extreme ids and payloads
    queue_req(REQ_ADD, 32'h8000_0000, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(REQ_ADD, 32'h7FFF_FFFF, 32'h0, 64'h0);
    queue_req(REQ_ADD, 32'hFFFF_FFFF, 32'h0, 64'h0123_4567_89AB_CDEF);
    queue_req(REQ_ADD, 32'h7FFF_FFFF, 32'h0, 64'h5555_5555_5555_5555);   // duplicate
    queue_req(REQ_GET, 32'h8000_0000, 32'h0, 64'h0);
    queue_req(REQ_GET, 32'h7FFF_FFFF, 32'h0, 64'h0);
    // update: clash with another entry, clash with missing target, plain miss
    queue_req(REQ_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF, 64'h0);
    queue_req(REQ_UPDATE, 32'h0000_0005, 32'hFFFF_FFFF, 64'h0);
    queue_req(REQ_UPDATE, 32'h0000_0005, 32'h0000_0006, 64'h0);
    // update onto its own id is no clash
    queue_req(REQ_UPDATE, 32'h8000_0000, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(REQ_UPDATE, 32'h7FFF_FFFF, 32'h0000_0000, 64'hA5A5_5A5A_C3C3_3C3C);
    queue_req(REQ_DELETE, 32'hFFFF_FFFF, 32'h0, 64'h0);                  // last slot
    queue_req(REQ_ADD,    32'h0000_0000, 32'h0, 64'h0);                  // duplicate
    queue_req(REQ_DELETE, 32'h8000_0000, 32'h0, 64'h0);                  // first slot, shift
    queue_req(REQ_GET,    32'h0000_0000, 32'h0, 64'h0);
    for (int k = REQ_RSVD_FIRST; k <= REQ_RSVD_LAST; k++) begin
      queue_req(k[REQ_W-1:0], $urandom, $urandom, {$urandom, $urandom});
    end
    queue_req(REQ_CLEAR, 32'h0, 32'h0, 64'h0);
    queue_req(REQ_GET,   32'h0, 32'h0, 64'h0);

    // Random phases; the count carries over, so lowering the capacity
    // below the entries held happens at the phase boundaries.
    run_phase(6'd32,  0,  0,  0, 200);
    run_phase(6'd63,  57, 0,  34, 200);   // above depth: fill hits the table size
    run_phase(6'd5,   0,  57, 0,  200);
    run_phase(6'd1,   37, 37, 0,  150);
    run_phase(6'd0,   0,  0,  0,  100);   // every add is full
    run_phase(6'd17,  37, 37, 0,  200);
    run_phase(6'd32,  57, 0,  0,  200);

    wait_drained();
    $display("Checked %0d results for %0d requests over %0d capacity settings.",
             checked_count, accepted_count, cap_writes);
    $display("Status mix: ok %0d full %0d dup %0d get-miss %0d del-miss %0d upd-miss %0d clash %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
             status_seen[ST_GET_MISS], status_seen[ST_DEL_MISS], status_seen[ST_UPD_MISS],
             status_seen[ST_UPD_CONFLICT]);
    if (fail_count == 0) begin
      $display("PASS keyed_entry_table");
    end else begin
      $display("FAIL keyed_entry_table");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("FAIL keyed_entry_table");
    $finish;
  end

endmodule
